### rtl/crsfd_pkg.sv
// Shared types, constants and the CRC-8 helper for the CRSF deframer.
package crsfd_pkg;

    localparam int BUF_DEPTH_DEF = 64;   // frame buffer entries
    localparam int MAX_RUN       = 63;   // most bytes in one emitted run
    localparam int IDX_W         = 6;    // byte position width
    localparam int BYTE_W        = 8;
    localparam int CMDQ_DEPTH    = 2;    // front-to-back command queue
    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] MIN_LEN  = 8'd2;

    // Result status codes, also used as command kinds on the queue
    typedef enum logic [1:0] {
        ST_FRAME = 2'd0,   // good frame: emit a run of bytes
        ST_CRC   = 2'd1,   // CRC mismatch, frame dropped
        ST_MAL   = 2'd2    // short or oversize length, frame dropped
    } status_t;

    typedef struct packed {
        status_t          kind;
        logic [IDX_W-1:0] len;    // L of a good frame
    } cmd_t;

    // CRC-8, polynomial 0xD5, MSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/crsfd_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module crsfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/crsfd_cmdq.sv
// Small command FIFO between the deframer front end and the emit back end.
module crsfd_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  crsfd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output crsfd_pkg::cmd_t head
);

    localparam int PW = (crsfd_pkg::CMDQ_DEPTH > 1) ? $clog2(crsfd_pkg::CMDQ_DEPTH) : 1;
    localparam int NW = $clog2(crsfd_pkg::CMDQ_DEPTH + 1);

    crsfd_pkg::cmd_t entry_reg [crsfd_pkg::CMDQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign full      = (count_reg == NW'(crsfd_pkg::CMDQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(crsfd_pkg::CMDQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(crsfd_pkg::CMDQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/crsfd_front.sv
// Front end: takes bytes, fills the frame buffer, tracks length and CRC.
module crsfd_front #(
    parameter int BUF_DEPTH = crsfd_pkg::BUF_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   rx_byte,
    input  logic                         flush,
    output logic                         wr_en,
    output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
    output logic [7:0]                   wr_data,
    output logic                         push,
    output crsfd_pkg::cmd_t              push_cmd,
    input  logic                         q_full,
    input  logic                         run_done
);

    localparam int AW      = $clog2(BUF_DEPTH);
    localparam int IW      = crsfd_pkg::IDX_W;
    // longest L accepted: the frame must fit the buffer and the run limit
    localparam int MAX_LEN = (BUF_DEPTH - 2 < crsfd_pkg::MAX_RUN - 1) ?
                             BUF_DEPTH - 2 : crsfd_pkg::MAX_RUN - 1;

    logic [IW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] len_reg, len_next;
    logic [7:0]    crc_reg, crc_next;
    logic          busy_reg, busy_next;   // good frame waiting in the buffer
    logic          accept;
    logic          len_ok;

    assign s_tready = !q_full && !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && !flush;
    assign wr_addr  = AW'(cnt_reg);
    assign wr_data  = rx_byte;
    assign len_ok   = (rx_byte >= crsfd_pkg::MIN_LEN) && (rx_byte <= 8'(MAX_LEN));

    always_comb
    begin
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        crc_next  = crc_reg;
        busy_next = busy_reg;
        push      = 1'b0;
        push_cmd  = '{kind: crsfd_pkg::ST_FRAME, len: len_reg};
        if (run_done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            priority if (flush)
            begin
                cnt_next = '0;
                len_next = '0;
                crc_next = '0;
            end
            else if (cnt_reg == '0)
            begin
                cnt_next = IW'(1);
            end
            else if (cnt_reg == IW'(1))
            begin
                if (len_ok)
                begin
                    len_next = rx_byte[IW-1:0];
                    cnt_next = IW'(2);
                    crc_next = '0;
                end
                else
                begin
                    push          = 1'b1;
                    push_cmd.kind = crsfd_pkg::ST_MAL;
                    cnt_next      = '0;
                    len_next      = '0;
                    crc_next      = '0;
                end
            end
            else if (cnt_reg <= len_reg)
            begin
                crc_next = crsfd_pkg::crc8_update(crc_reg, rx_byte);
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                // CRC byte
                push = 1'b1;
                if (rx_byte == crc_reg)
                begin
                    push_cmd.kind = crsfd_pkg::ST_FRAME;
                    busy_next     = 1'b1;
                end
                else
                begin
                    push_cmd.kind = crsfd_pkg::ST_CRC;
                end
                cnt_next = '0;
                len_next = '0;
                crc_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            len_reg  <= '0;
            crc_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
            crc_reg  <= crc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

### rtl/crsfd_back.sv
// Back end: pops commands, streams good frames out of the frame buffer and emits status results.
module crsfd_back #(
    parameter int BUF_DEPTH = crsfd_pkg::BUF_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_not_empty,
    input  crsfd_pkg::cmd_t              q_head,
    output logic                         pop,
    output logic                         rd_en,
    output logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
    input  logic [7:0]                   rd_data,
    output logic                         run_done,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   frame_byte,
    output logic [crsfd_pkg::IDX_W-1:0]  byte_index,
    output logic                         last_byte,
    output crsfd_pkg::status_t           status
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int IW = crsfd_pkg::IDX_W;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;       // next address to read
    logic [IW-1:0] len_reg, len_next;
    logic          pend_reg, pend_next;     // read data waiting in the RAM register
    logic [IW-1:0] pidx_reg, pidx_next;     // index of that data
    logic          plast_reg, plast_next;
    logic          ov_reg, ov_next;
    logic [7:0]    ob_reg, ob_next;
    logic [IW-1:0] oi_reg, oi_next;
    logic          ol_reg, ol_next;
    crsfd_pkg::status_t os_reg, os_next;
    logic          out_free;
    logic          move;

    assign out_free = !ov_reg || m_tready;
    assign move     = pend_reg && out_free;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        plast_next = plast_reg;
        ov_next    = ov_reg;
        ob_next    = ob_reg;
        oi_next    = oi_reg;
        ol_next    = ol_reg;
        os_next    = os_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        run_done   = 1'b0;

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end
        if (move)
        begin
            ov_next   = 1'b1;
            ob_next   = rd_data;
            oi_next   = pidx_reg;
            ol_next   = plast_reg;
            os_next   = crsfd_pkg::ST_FRAME;
            pend_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty && !pend_reg)
                begin
                    if (q_head.kind == crsfd_pkg::ST_FRAME)
                    begin
                        pop        = 1'b1;
                        idx_next   = '0;
                        len_next   = q_head.len;
                        state_next = S_RUN;
                    end
                    else if (out_free)
                    begin
                        pop     = 1'b1;
                        ov_next = 1'b1;
                        ob_next = '0;
                        oi_next = '0;
                        ol_next = 1'b1;
                        os_next = q_head.kind;
                    end
                end
            end
            S_RUN:
            begin
                if (!pend_reg || move)
                begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    pidx_next  = idx_reg;
                    plast_next = (idx_reg == len_reg);
                    idx_next   = idx_reg + 1'b1;
                    if (idx_reg == len_reg)
                    begin
                        run_done   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr    = AW'(idx_reg);
    assign m_tvalid   = ov_reg;
    assign frame_byte = ob_reg;
    assign byte_index = oi_reg;
    assign last_byte  = ol_reg;
    assign status     = os_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            len_reg   <= '0;
            pidx_reg  <= '0;
            plast_reg <= 1'b0;
            ob_reg    <= '0;
            oi_reg    <= '0;
            ol_reg    <= 1'b0;
            os_reg    <= crsfd_pkg::ST_FRAME;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            pidx_reg  <= pidx_next;
            plast_reg <= plast_next;
            ob_reg    <= ob_next;
            oi_reg    <= oi_next;
            ol_reg    <= ol_next;
            os_reg    <= os_next;
        end
    end

endmodule

### rtl/crsf_frame_deframer_unit.sv
// Top level of the CRSF frame deframer with CRC-8 (DVB-S2) check.
//
// Received bytes come in on the slave stream, one per transaction; s_tuser set
// means flush (drop any partial frame, byte ignored). Byte 0 of a frame is the
// address, byte 1 the length L, the frame is L+2 bytes and its last byte is a
// CRC-8 (poly 0xD5, init 0, MSB first) over bytes 2..L. A good frame comes out
// as a run of L+1 transactions (address through last payload byte) with
// m_tuser = 0 and m_tlast on the final one. A CRC mismatch gives one
// transaction with status 1; L below 2, or a frame that does not fit the
// buffer or a 63-byte run, gives one with status 2 as soon as L arrives.
// Status results carry zero data, index 0 and m_tlast set.
// Rate: the front end takes one byte per cycle while s_tready is high. Once a
// good frame's CRC byte is in, s_tready stays low until the back end has issued
// the last read of the single frame buffer. The back end pops the command after
// the CRC byte and then reads one byte per cycle while the output keeps moving;
// a stalled m_tready or error results still waiting ahead of the frame keep
// s_tready low for longer. Error results only stop the front end when the
// two-entry command queue is full.
// No clearing pass after reset: every buffer entry is written before it is read.
module crsf_frame_deframer_unit #(
    parameter int BUF_DEPTH = crsfd_pkg::BUF_DEPTH_DEF   // 8..257
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] flush
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
    output logic        m_tlast,   // last_byte
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int AW = $clog2(BUF_DEPTH);

    // frame buffer ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // command queue
    logic            push, pop, q_full, q_not_empty;
    crsfd_pkg::cmd_t push_cmd, q_head;
    logic            run_done;

    logic [7:0]                  frame_byte;
    logic [crsfd_pkg::IDX_W-1:0] byte_index;
    crsfd_pkg::status_t          status;

    crsfd_front #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .rx_byte  (s_tdata),
        .flush    (s_tuser),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full),
        .run_done (run_done)
    );

    crsfd_ram #(
        .WIDTH(crsfd_pkg::BYTE_W),
        .DEPTH(BUF_DEPTH)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crsfd_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    crsfd_back #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .run_done    (run_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .frame_byte  (frame_byte),
        .byte_index  (byte_index),
        .last_byte   (m_tlast),
        .status      (status)
    );

    assign m_tdata = {2'b00, byte_index, frame_byte};
    assign m_tuser = status;

endmodule
